### rtl/mlbc_pkg.sv
// Package: shared constants, codes and types of the multi-LED blink controller.
package mlbc_pkg;

	// Number of LEDs driven by the block.
	localparam int NUM_LEDS = 3;

	// Field and register widths.
	localparam int OP_W    = 2;
	localparam int IDX_W   = 2;
	localparam int MODE_W  = 3;
	localparam int MASK_W  = 3;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Saturation value of the elapsed-tick counters.
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Register reset values.
	localparam logic [CFG_W-1:0] FAST_RESET   = 16'd100;
	localparam logic [CFG_W-1:0] SLOW_RESET   = 16'd500;
	localparam logic [CFG_W-1:0] SINGLE_RESET = 16'd50;

	// Operation codes of an input word.
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_BLINK = 2'd2
	} op_t;

	// LED modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_OFF    = 3'd0,
		MODE_ON     = 3'd1,
		MODE_FAST   = 3'd2,
		MODE_SLOW   = 3'd3,
		MODE_SINGLE = 3'd4
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST   = 2'd0,
		CFG_SLOW   = 2'd1,
		CFG_SINGLE = 2'd2
	} cfg_reg_t;

	// Timing registers as seen by every LED.
	typedef struct packed {
		logic [CFG_W-1:0] fast_interval;
		logic [CFG_W-1:0] slow_interval;
		logic [CFG_W-1:0] single_time;
	} timing_t;

	// Per-LED command for the word being retired this cycle.
	typedef struct packed {
		logic  tick;
		logic  set_mode;
		logic  blink_once;
		mode_t mode;
	} led_cmd_t;

endpackage

### rtl/mlbc_if.sv
// Interfaces: request and response channels of the multi-LED blink controller.
interface mlbc_req_if
	import mlbc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [IDX_W-1:0]  led_index;
	logic [MODE_W-1:0] mode;

	modport source (output valid, output op, output led_index, output mode, input ready);
	modport sink   (input valid, input op, input led_index, input mode, output ready);
endinterface

interface mlbc_rsp_if
	import mlbc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] lit_mask;

	modport source (output valid, output lit_mask, input ready);
	modport sink   (input valid, input lit_mask, output ready);
endinterface

### rtl/multi_led_blink_controller.sv
// Top level: multi-LED blink controller with input register, LED units and result register.
//
//   channel | dir | payload                  | handshake
//   req     | in  | op, led_index, mode      | valid / ready
//   rsp     | out | lit_mask                 | valid / ready
//   cfg     | in  | cfg_index, cfg_data      | cfg_we, no wait
//
// One word per cycle sustained while rsp.ready stays high.
// The word sits in the input register, the LED units update from it, and the new lit
// mask is loaded into the result register in the same cycle.
// Reset sets every LED off and dark, counters to zero and the intervals to 100, 500, 50.
// A stalled result holds the input register; req.ready drops only when both are full.
module multi_led_blink_controller
	import mlbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	mlbc_req_if.sink             req,
	mlbc_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [MODE_W-1:0] mode_s1;
	logic              rsp_valid_q;
	logic [MASK_W-1:0] lit_mask_q;
	logic              advance;
	logic              idx_ok;
	logic              mode_ok;
	timing_t           timing_q;
	logic [NUM_LEDS-1:0] lit_nxt;
	logic [MASK_W-1:0] mask_nxt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.fast_interval <= FAST_RESET;
			timing_q.slow_interval <= SLOW_RESET;
			timing_q.single_time   <= SINGLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FAST:   timing_q.fast_interval <= cfg_data;
				CFG_SLOW:   timing_q.slow_interval <= cfg_data;
				CFG_SINGLE: timing_q.single_time   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The word in the input register retires when the result register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1   <= req.op;
			idx_s1  <= req.led_index;
			mode_s1 <= req.mode;
		end
	end

	// Range checks on the addressed LED and the requested mode.
	assign idx_ok  = 32'(idx_s1) < NUM_LEDS;
	assign mode_ok = mode_s1 <= MODE_SINGLE;

	// One unit per LED, each given its decoded command.
	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
		led_cmd_t cmd;
		logic     hit;

		assign hit = advance && idx_ok && (32'(idx_s1) == i);

		always_comb begin
			cmd.tick       = 1'b0;
			cmd.set_mode   = 1'b0;
			cmd.blink_once = 1'b0;
			cmd.mode       = mode_t'(mode_s1);
			unique case (op_t'(op_s1))
				OP_TICK:  cmd.tick       = advance;
				OP_SET:   cmd.set_mode   = hit && mode_ok;
				OP_BLINK: cmd.blink_once = hit;
				default: ;
			endcase
		end

		mlbc_led u_led (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.timing  (timing_q),
			.lit_nxt (lit_nxt[i])
		);
	end

	// Lit mask after this word; LEDs beyond the mask width do not appear.
	for (genvar b = 0; b < MASK_W; b++) begin : g_mask
		if (b < NUM_LEDS) begin : g_used
			assign mask_nxt[b] = lit_nxt[b];
		end else begin : g_unused
			assign mask_nxt[b] = 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lit_mask_q <= mask_nxt;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.lit_mask = lit_mask_q;

endmodule

### rtl/mlbc_led.sv
// Module: state and update rules of one LED (mode, tick counter, toggle and lit bits).
module mlbc_led
	import mlbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  led_cmd_t cmd,
	input  timing_t  timing,
	output logic     lit_nxt
);

	mode_t            mode_q, mode_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             toggle_q, toggle_d;
	logic             lit_q, lit_d;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] limit;

	// Saturating increment and the interval of the current blink mode.
	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign limit   = (mode_q == MODE_FAST) ? timing.fast_interval : timing.slow_interval;

	// Next state for a tick, a mode change or a single flash.
	always_comb begin
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		toggle_d = toggle_q;
		lit_d    = lit_q;
		if (cmd.tick) begin
			cnt_d = cnt_inc;
			unique case (mode_q)
				MODE_FAST, MODE_SLOW: begin
					if (cnt_inc >= limit) begin
						toggle_d = ~toggle_q;
						lit_d    = ~toggle_q;
						cnt_d    = '0;
					end
				end
				MODE_SINGLE: begin
					if (cnt_inc >= timing.single_time) begin
						lit_d  = 1'b0;
						mode_d = MODE_OFF;
					end
				end
				default: ;
			endcase
		end else if (cmd.set_mode) begin
			mode_d = cmd.mode;
			cnt_d  = '0;
			if (cmd.mode == MODE_ON) begin
				lit_d = 1'b1;
			end else if (cmd.mode == MODE_OFF) begin
				lit_d = 1'b0;
			end
		end else if (cmd.blink_once) begin
			mode_d = MODE_SINGLE;
			cnt_d  = '0;
			lit_d  = 1'b1;
		end
	end

	// LED state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			cnt_q    <= '0;
			toggle_q <= 1'b0;
			lit_q    <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			cnt_q    <= cnt_d;
			toggle_q <= toggle_d;
			lit_q    <= lit_d;
		end
	end

	assign lit_nxt = lit_d;

endmodule
